// ===== rtl/tun_pkg.sv =====
// Package for the triangle unit normal block: widths, payload structs.
// No dependencies; used by every other file of the block.
`default_nettype none
package tun_pkg;

    localparam int COORD_W = 16;              // vertex coordinate, Q8.8
    localparam int EDGE_W  = COORD_W + 1;     // exact edge difference
    localparam int PROD_W  = 2 * EDGE_W;      // edge product
    localparam int CROSS_W = PROD_W + 1;      // cross product component
    localparam int MAG_W   = CROSS_W - 1;     // its magnitude
    localparam int V_W     = 16;              // normalized magnitude
    localparam int SQ_W    = 2 * V_W;
    localparam int SUM_W   = SQ_W + 2;        // sum of three squares
    localparam int RHS_W   = SQ_W + 30;       // (2^15 * v)^2
    localparam int P_W     = 64;              // (2k-1)^2 * S
    localparam int Q_W     = SUM_W + 18;      // (2k-1) * S, signed
    localparam int ACC_W   = 68;              // candidate sum width
    localparam int K_W     = 15;              // result magnitude, up to 16384
    localparam int OUT_W   = 16;              // Q2.14 output
    localparam int SH_W    = 6;

    typedef struct packed {
        logic signed [CROSS_W-1:0] nx;
        logic signed [CROSS_W-1:0] ny;
        logic signed [CROSS_W-1:0] nz;
    } cross_t;

    typedef struct packed {
        logic [P_W-1:0]   p;
        logic [Q_W-1:0]   q;
        logic [K_W-1:0]   k;
        logic [RHS_W-1:0] rhs;
        logic             neg;
    } lane_t;

    typedef struct packed {
        lane_t [2:0]      ln;
        logic [SUM_W-1:0] sum;
        logic             deg;
    } iter_t;

    typedef struct packed {
        logic [2:0][RHS_W-1:0] rhs;
        logic [2:0]            neg;
        logic [SUM_W-1:0]      sum;
        logic                  deg;
    } norm_t;

endpackage
`default_nettype wire

// ===== rtl/tun_tri_if.sv =====
// Input channel: one triangle word, three Q8.8 vertices.
// Depends on tun_pkg.
`default_nettype none
interface tun_tri_if;
    logic valid;
    logic ready;
    logic signed [tun_pkg::COORD_W-1:0] first_x;
    logic signed [tun_pkg::COORD_W-1:0] first_y;
    logic signed [tun_pkg::COORD_W-1:0] first_z;
    logic signed [tun_pkg::COORD_W-1:0] second_x;
    logic signed [tun_pkg::COORD_W-1:0] second_y;
    logic signed [tun_pkg::COORD_W-1:0] second_z;
    logic signed [tun_pkg::COORD_W-1:0] third_x;
    logic signed [tun_pkg::COORD_W-1:0] third_y;
    logic signed [tun_pkg::COORD_W-1:0] third_z;

    modport source (output valid, first_x, first_y, first_z, second_x, second_y,
                    second_z, third_x, third_y, third_z, input ready);
    modport sink   (input valid, first_x, first_y, first_z, second_x, second_y,
                    second_z, third_x, third_y, third_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/tun_nrm_if.sv =====
// Output channel: one unit normal word in Q2.14 plus degenerate flag.
// Depends on tun_pkg.
`default_nettype none
interface tun_nrm_if;
    logic valid;
    logic ready;
    logic signed [tun_pkg::OUT_W-1:0] normal_x;
    logic signed [tun_pkg::OUT_W-1:0] normal_y;
    logic signed [tun_pkg::OUT_W-1:0] normal_z;
    logic degenerate;

    modport source (output valid, normal_x, normal_y, normal_z, degenerate,
                    input ready);
    modport sink   (input valid, normal_x, normal_y, normal_z, degenerate,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/tun_cross.sv =====
// Edge vectors and cross product, three register stages.
// Depends on tun_pkg and tun_tri_if.
`default_nettype none
module tun_cross (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tun_tri_if.sink     vtx,
    output logic        out_valid,
    input  wire logic   out_ready,
    output tun_pkg::cross_t out_data
);
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic s1_rdy, s2_rdy, s3_rdy;

    logic signed [tun_pkg::EDGE_W-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [tun_pkg::EDGE_W-1:0] ax_next, ay_next, az_next, bx_next, by_next, bz_next;
    logic signed [tun_pkg::PROD_W-1:0] p_yz_reg, p_zy_reg, p_zx_reg, p_xz_reg, p_xy_reg, p_yx_reg;
    logic signed [tun_pkg::PROD_W-1:0] p_yz_next, p_zy_next, p_zx_next, p_xz_next, p_xy_next,
                                       p_yx_next;
    tun_pkg::cross_t cr_reg, cr_next;

    assign s3_rdy    = !s3_vld_reg || out_ready;
    assign s2_rdy    = !s2_vld_reg || s3_rdy;
    assign s1_rdy    = !s1_vld_reg || s2_rdy;
    assign vtx.ready = s1_rdy;

    always_comb
    begin
        ax_next = tun_pkg::EDGE_W'(vtx.second_x) - tun_pkg::EDGE_W'(vtx.first_x);
        ay_next = tun_pkg::EDGE_W'(vtx.second_y) - tun_pkg::EDGE_W'(vtx.first_y);
        az_next = tun_pkg::EDGE_W'(vtx.second_z) - tun_pkg::EDGE_W'(vtx.first_z);
        bx_next = tun_pkg::EDGE_W'(vtx.third_x) - tun_pkg::EDGE_W'(vtx.first_x);
        by_next = tun_pkg::EDGE_W'(vtx.third_y) - tun_pkg::EDGE_W'(vtx.first_y);
        bz_next = tun_pkg::EDGE_W'(vtx.third_z) - tun_pkg::EDGE_W'(vtx.first_z);
    end

    always_comb
    begin
        p_yz_next = tun_pkg::PROD_W'(ay_reg) * tun_pkg::PROD_W'(bz_reg);
        p_zy_next = tun_pkg::PROD_W'(az_reg) * tun_pkg::PROD_W'(by_reg);
        p_zx_next = tun_pkg::PROD_W'(az_reg) * tun_pkg::PROD_W'(bx_reg);
        p_xz_next = tun_pkg::PROD_W'(ax_reg) * tun_pkg::PROD_W'(bz_reg);
        p_xy_next = tun_pkg::PROD_W'(ax_reg) * tun_pkg::PROD_W'(by_reg);
        p_yx_next = tun_pkg::PROD_W'(ay_reg) * tun_pkg::PROD_W'(bx_reg);
    end

    always_comb
    begin
        cr_next.nx = tun_pkg::CROSS_W'(p_yz_reg) - tun_pkg::CROSS_W'(p_zy_reg);
        cr_next.ny = tun_pkg::CROSS_W'(p_zx_reg) - tun_pkg::CROSS_W'(p_xz_reg);
        cr_next.nz = tun_pkg::CROSS_W'(p_xy_reg) - tun_pkg::CROSS_W'(p_yx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy) s1_vld_reg <= vtx.valid;
            if (s2_rdy) s2_vld_reg <= s1_vld_reg;
            if (s3_rdy) s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy)
        begin
            ax_reg <= ax_next; ay_reg <= ay_next; az_reg <= az_next;
            bx_reg <= bx_next; by_reg <= by_next; bz_reg <= bz_next;
        end
        if (s2_rdy)
        begin
            p_yz_reg <= p_yz_next; p_zy_reg <= p_zy_next; p_zx_reg <= p_zx_next;
            p_xz_reg <= p_xz_next; p_xy_reg <= p_xy_next; p_yx_reg <= p_yx_next;
        end
        if (s3_rdy)
            cr_reg <= cr_next;
    end

    assign out_valid = s3_vld_reg;
    assign out_data  = cr_reg;
endmodule
`default_nettype wire

// ===== rtl/tun_norm.sv =====
// Magnitude normalization to 16 bits, squares and their sum; four stages.
// Depends on tun_pkg.
`default_nettype none
module tun_norm (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire tun_pkg::cross_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output tun_pkg::norm_t       out_data
);
    logic [3:0] vld_reg;
    logic [3:0] rdy;

    logic [2:0][tun_pkg::MAG_W-1:0] mag_reg, mag_next;
    logic [tun_pkg::MAG_W-1:0]      orw_reg, orw_next;
    logic [2:0] neg4_reg, neg4_next, neg5_reg, neg6_reg;
    logic deg4_reg, deg4_next, deg5_reg, deg6_reg;
    logic [2:0][tun_pkg::V_W-1:0]  v_reg, v_next;
    logic [tun_pkg::SH_W-1:0]      sh;
    logic [2:0][tun_pkg::SQ_W-1:0] sq_reg, sq_next;
    tun_pkg::norm_t nrm_reg, nrm_next;

    assign rdy[3]   = !vld_reg[3] || out_ready;
    assign rdy[2]   = !vld_reg[2] || rdy[3];
    assign rdy[1]   = !vld_reg[1] || rdy[2];
    assign rdy[0]   = !vld_reg[0] || rdy[1];
    assign in_ready = rdy[0];

    always_comb
    begin
        neg4_next = {in_data.nz[tun_pkg::CROSS_W-1], in_data.ny[tun_pkg::CROSS_W-1],
                     in_data.nx[tun_pkg::CROSS_W-1]};
        mag_next[0] = tun_pkg::MAG_W'(neg4_next[0] ? -in_data.nx : in_data.nx);
        mag_next[1] = tun_pkg::MAG_W'(neg4_next[1] ? -in_data.ny : in_data.ny);
        mag_next[2] = tun_pkg::MAG_W'(neg4_next[2] ? -in_data.nz : in_data.nz);
        orw_next  = mag_next[0] | mag_next[1] | mag_next[2];
        deg4_next = (orw_next == '0);
    end

    // common right shift so the largest magnitude fits in V_W bits
    always_comb
    begin
        sh = '0;
        for (int i = tun_pkg::V_W; i < tun_pkg::MAG_W; i++)
        begin
            if (orw_reg[i])
                sh = tun_pkg::SH_W'(i - tun_pkg::V_W + 1);
        end
        for (int l = 0; l < 3; l++)
            v_next[l] = tun_pkg::V_W'(mag_reg[l] >> sh);
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
            sq_next[l] = tun_pkg::SQ_W'(v_reg[l]) * tun_pkg::SQ_W'(v_reg[l]);
    end

    always_comb
    begin
        nrm_next.sum = tun_pkg::SUM_W'(sq_reg[0]) + tun_pkg::SUM_W'(sq_reg[1])
                     + tun_pkg::SUM_W'(sq_reg[2]);
        for (int l = 0; l < 3; l++)
            nrm_next.rhs[l] = {sq_reg[l], 30'b0};
        nrm_next.neg = neg6_reg;
        nrm_next.deg = deg6_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (rdy[0]) vld_reg[0] <= in_valid;
            if (rdy[1]) vld_reg[1] <= vld_reg[0];
            if (rdy[2]) vld_reg[2] <= vld_reg[1];
            if (rdy[3]) vld_reg[3] <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            mag_reg <= mag_next; orw_reg <= orw_next;
            neg4_reg <= neg4_next; deg4_reg <= deg4_next;
        end
        if (rdy[1])
        begin
            v_reg <= v_next; neg5_reg <= neg4_reg; deg5_reg <= deg4_reg;
        end
        if (rdy[2])
        begin
            sq_reg <= sq_next; neg6_reg <= neg5_reg; deg6_reg <= deg5_reg;
        end
        if (rdy[3])
            nrm_reg <= nrm_next;
    end

    assign out_valid = vld_reg[3];
    assign out_data  = nrm_reg;
endmodule
`default_nettype wire

// ===== rtl/tun_root.sv =====
// Rounded v*2^14/sqrt(S): one result bit per stage, three lanes, 15 stages.
// Depends on tun_pkg and tun_nrm_if. Last stage is the output register.
`default_nettype none
module tun_root (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire tun_pkg::norm_t in_data,
    tun_nrm_if.source           nrm
);
    localparam int NSTG = tun_pkg::K_W;

    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   rdy;
    tun_pkg::iter_t  stg_reg  [NSTG];
    tun_pkg::iter_t  stg_next [NSTG];
    tun_pkg::iter_t  init;

    assign rdy[NSTG] = nrm.ready;
    assign in_ready  = rdy[0];

    // k = 0: (2k-1)^2 S = S, (2k-1) S = -S
    always_comb
    begin
        init.sum = in_data.sum;
        init.deg = in_data.deg;
        for (int l = 0; l < 3; l++)
        begin
            init.ln[l].p   = tun_pkg::P_W'(in_data.sum);
            init.ln[l].q   = tun_pkg::Q_W'(0) - tun_pkg::Q_W'(in_data.sum);
            init.ln[l].k   = '0;
            init.ln[l].rhs = in_data.rhs[l];
            init.ln[l].neg = in_data.neg[l];
        end
    end

    for (genvar j = 0; j < NSTG; j++)
    begin : g_stg
        localparam int BI = NSTG - 1 - j;
        tun_pkg::iter_t src;
        logic [tun_pkg::ACC_W-1:0] pc  [3];
        logic [tun_pkg::ACC_W-1:0] qx  [3];
        logic                      take[3];

        if (j == 0)
        begin : g_first
            assign src = init;
        end
        else
        begin : g_rest
            assign src = stg_reg[j-1];
        end

        assign rdy[j] = !vld_reg[j] || rdy[j+1];

        // t' = t + 2b: t'^2 S = t^2 S + 4b (t S) + 4b^2 S
        always_comb
        begin
            stg_next[j] = src;
            for (int l = 0; l < 3; l++)
            begin
                qx[l] = {{(tun_pkg::ACC_W-tun_pkg::Q_W){src.ln[l].q[tun_pkg::Q_W-1]}},
                         src.ln[l].q};
                pc[l] = tun_pkg::ACC_W'(src.ln[l].p) + (qx[l] << (BI + 2))
                      + (tun_pkg::ACC_W'(src.sum) << (2 * BI + 2));
                take[l] = !src.ln[l].k[tun_pkg::K_W-1]
                       && (pc[l] <= tun_pkg::ACC_W'(src.ln[l].rhs));
                if (take[l])
                begin
                    stg_next[j].ln[l].p = tun_pkg::P_W'(pc[l]);
                    stg_next[j].ln[l].q = src.ln[l].q
                                        + (tun_pkg::Q_W'(src.sum) << (BI + 1));
                    stg_next[j].ln[l].k = src.ln[l].k | (tun_pkg::K_W'(1) << BI);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[j] <= 1'b0;
            else if (rdy[j])
                vld_reg[j] <= (j == 0) ? in_valid : vld_reg[(j == 0) ? 0 : j-1];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[j])
                stg_reg[j] <= stg_next[j];
        end
    end

    logic [tun_pkg::OUT_W-1:0] kk [3];
    logic [tun_pkg::OUT_W-1:0] res[3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            kk[l]  = tun_pkg::OUT_W'(stg_reg[NSTG-1].ln[l].k);
            res[l] = stg_reg[NSTG-1].deg ? '0
                   : (stg_reg[NSTG-1].ln[l].neg ? -kk[l] : kk[l]);
        end
    end

    assign nrm.valid      = vld_reg[NSTG-1];
    assign nrm.normal_x   = res[0];
    assign nrm.normal_y   = res[1];
    assign nrm.normal_z   = res[2];
    assign nrm.degenerate = stg_reg[NSTG-1].deg;
endmodule
`default_nettype wire

// ===== rtl/triangle_unit_normal_top.sv =====
// Throughput: one triangle per cycle while nrm.ready holds; 22 register stages
// (3 cross product, 4 normalize, 15 one-bit root steps), each holding one word.
// A stalled stage holds its word; ready ripples back through empty stages.
// Reset clears every stage valid bit; data registers are not reset.
// Top level; depends on tun_pkg, tun_tri_if, tun_nrm_if, tun_cross, tun_norm, tun_root.
`default_nettype none
module triangle_unit_normal_top (
    input  wire logic clk,
    input  wire logic rst_n,
    tun_tri_if.sink   vtx,
    tun_nrm_if.source nrm
);
    logic            cr_valid, cr_ready;
    tun_pkg::cross_t cr_data;
    logic            nm_valid, nm_ready;
    tun_pkg::norm_t  nm_data;

    tun_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx       (vtx),
        .out_valid (cr_valid),
        .out_ready (cr_ready),
        .out_data  (cr_data)
    );

    tun_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cr_valid),
        .in_ready  (cr_ready),
        .in_data   (cr_data),
        .out_valid (nm_valid),
        .out_ready (nm_ready),
        .out_data  (nm_data)
    );

    tun_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (nm_valid),
        .in_ready (nm_ready),
        .in_data  (nm_data),
        .nrm      (nrm)
    );

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        nrm.valid && nrm.degenerate |->
            nrm.normal_x == '0 && nrm.normal_y == '0 && nrm.normal_z == '0)
        else $error("degenerate word with nonzero normal");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        nrm.valid |->
            nrm.normal_x >= -16'sd16384 && nrm.normal_x <= 16'sd16384 &&
            nrm.normal_y >= -16'sd16384 && nrm.normal_y <= 16'sd16384 &&
            nrm.normal_z >= -16'sd16384 && nrm.normal_z <= 16'sd16384)
        else $error("normal component out of unit range");

    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !nrm.valid |-> vtx.ready)
        else $error("input blocked while output stage empty");
endmodule
`default_nettype wire

// ===== tb/tb_triangle_unit_normal_top.sv =====
// Testbench for triangle_unit_normal_top: drives triangle words, predicts the
// Q2.14 unit normal of each, and checks every normal word in order.
// Depends on tun_pkg, tun_tri_if, tun_nrm_if and the block RTL.
`default_nettype none

class normal_scoreboard;
    logic [15:0] exp_x[$];
    logic [15:0] exp_y[$];
    logic [15:0] exp_z[$];
    logic        exp_deg[$];
    int          errors;
    int          checked;
    int          degen_seen;

    static function logic [63:0] magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Round v * 2^14 / sqrt(s), ties up, by testing candidate bits.
    static function logic [14:0] unit_mag(logic [63:0] v, logic [63:0] s);
        logic [63:0] k;
        logic [63:0] c;
        logic [63:0] t;
        logic [127:0] rhs;
        k = 0;
        rhs = ({64'd0, v} << 15) * ({64'd0, v} << 15);
        for (int b = 14; b >= 0; b--)
        begin
            c = k | (64'd1 << b);
            if (c <= 16384)
            begin
                t = 2 * c - 1;
                if ({64'd0, t} * {64'd0, t} * {64'd0, s} <= rhs)
                    k = c;
            end
        end
        return k[14:0];
    endfunction

    function void note_triangle(logic signed [15:0] p[9]);
        longint a[3];
        longint b[3];
        longint n[3];
        logic [63:0] mx;
        logic [63:0] s;
        logic [63:0] m;
        logic [14:0] k;
        logic [15:0] r[3];
        int sh;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = longint'(p[3 + i]) - longint'(p[i]);
            b[i] = longint'(p[6 + i]) - longint'(p[i]);
        end
        n[0] = a[1] * b[2] - a[2] * b[1];
        n[1] = a[2] * b[0] - a[0] * b[2];
        n[2] = a[0] * b[1] - a[1] * b[0];
        if (n[0] == 0 && n[1] == 0 && n[2] == 0)
        begin
            exp_x.push_back(0); exp_y.push_back(0); exp_z.push_back(0);
            exp_deg.push_back(1);
            return;
        end
        mx = 0;
        for (int i = 0; i < 3; i++)
            if (magnitude(n[i]) > mx)
                mx = magnitude(n[i]);
        sh = 0;
        while ((mx >> sh) >= 64'h10000)
            sh++;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            m = magnitude(n[i]) >> sh;
            s += m * m;
        end
        for (int i = 0; i < 3; i++)
        begin
            k = unit_mag(magnitude(n[i]) >> sh, s);
            r[i] = n[i] < 0 ? -{1'b0, k} : {1'b0, k};
        end
        exp_x.push_back(r[0]); exp_y.push_back(r[1]); exp_z.push_back(r[2]);
        exp_deg.push_back(0);
    endfunction

    function int pending();
        return exp_deg.size();
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0h expected %0h (word %0d)", what, got, want, checked);
        errors++;
    endtask

    task check_normal(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic d);
        logic [15:0] ex;
        logic [15:0] ey;
        logic [15:0] ez;
        logic ed;
        if (exp_deg.size() == 0)
        begin
            report("unexpected word", x, 0);
            return;
        end
        ex = exp_x.pop_front(); ey = exp_y.pop_front(); ez = exp_z.pop_front();
        ed = exp_deg.pop_front();
        if (x !== ex) report("normal_x", x, ex);
        if (y !== ey) report("normal_y", y, ey);
        if (z !== ez) report("normal_z", z, ez);
        if (d !== ed) report("degenerate", {15'd0, d}, {15'd0, ed});
        if (d === 1'b1) degen_seen++;
        checked++;
    endtask
endclass

module tb_triangle_unit_normal_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    logic clk;
    logic rst_n;
    int   send_idle;   // percent
    int   recv_stall;  // percent
    int   idle_cycles;
    int   sent;
    bit   timed_out;

    tun_tri_if vtx ();
    tun_nrm_if nrm ();
    normal_scoreboard sb;

    triangle_unit_normal_top DUT (.clk(clk), .rst_n(rst_n), .vtx(vtx.sink), .nrm(nrm.source));

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Result side: random stalls, check on each accepted word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nrm.ready <= 0;
        else
        begin
            if (nrm.valid && nrm.ready)
                sb.check_normal(nrm.normal_x, nrm.normal_y, nrm.normal_z, nrm.degenerate);
            nrm.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Watchdog on cycles with no handshake.
    always @(posedge clk)
    begin
        if ((vtx.valid && vtx.ready) || (nrm.valid && nrm.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("watchdog expired, %0d words outstanding", sb.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    // valid stays high from the previous word unless the sender idles
    task send_triangle(logic signed [15:0] p[9]);
        while ($urandom_range(99) < send_idle)
        begin
            vtx.valid <= 0;
            @(posedge clk);
        end
        vtx.valid <= 1;
        {vtx.first_x, vtx.first_y, vtx.first_z} <= {p[0], p[1], p[2]};
        {vtx.second_x, vtx.second_y, vtx.second_z} <= {p[3], p[4], p[5]};
        {vtx.third_x, vtx.third_y, vtx.third_z} <= {p[6], p[7], p[8]};
        do
            @(posedge clk);
        while (!vtx.ready);
        sb.note_triangle(p);
        sent++;
    endtask

    task send_fields(logic signed [15:0] a, logic signed [15:0] b, logic signed [15:0] c,
                     logic signed [15:0] d, logic signed [15:0] e, logic signed [15:0] f,
                     logic signed [15:0] g, logic signed [15:0] h, logic signed [15:0] i);
        logic signed [15:0] p[9];
        p = '{a, b, c, d, e, f, g, h, i};
        send_triangle(p);
    endtask

    function logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(7) - 4);           // small, often collinear
            2: return $urandom_range(1) ? 16'(16'h7fff - $urandom_range(3))
                                        : 16'(16'h8000 + $urandom_range(3));
            default: return 16'($urandom_range(2047) - 1024);
        endcase
    endfunction

    task send_random(int count);
        logic signed [15:0] p[9];
        int mode;
        int t;
        for (int n = 0; n < count; n++)
        begin
            mode = $urandom_range(3);
            for (int i = 0; i < 9; i++)
                p[i] = rand_coord($urandom_range(4) == 0 ? $urandom_range(3) : mode);
            t = $urandom_range(9);
            if (t == 0)
                for (int i = 0; i < 3; i++) p[6 + i] = p[3 + i];     // repeated vertex
            else if (t == 1)
                for (int i = 0; i < 3; i++)                          // collinear points
                    p[6 + i] = 16'(p[i] + 2 * (p[3 + i] - p[i]));
            send_triangle(p);
        end
    endtask

    task drain();
        vtx.valid <= 0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        send_idle = 0;
        recv_stall = 0;
        idle_cycles = 0;
        sent = 0;
        vtx.valid = 0;
        {vtx.first_x, vtx.first_y, vtx.first_z} = '0;
        {vtx.second_x, vtx.second_y, vtx.second_z} = '0;
        {vtx.third_x, vtx.third_y, vtx.third_z} = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: degenerate, axis-aligned, full-range corners, ties.
        send_fields(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_fields(5, 5, 5, 5, 5, 5, 5, 5, 5);
        send_fields(0, 0, 0, 1, 1, 1, 2, 2, 2);
        send_fields(0, 0, 0, 256, 0, 0, 0, 256, 0);
        send_fields(0, 0, 0, 0, 256, 0, 256, 0, 0);
        send_fields(0, 0, 0, 0, 256, 0, 0, 0, 256);
        send_fields(0, 0, 0, 0, 0, 256, 256, 0, 0);
        send_fields(0, 0, 0, 1, 0, 0, 0, 1, 0);
        send_fields(0, 0, 0, 1, 0, 0, 1, 1, 1);
        send_fields(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768);
        send_fields(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, -32768);
        send_fields(-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767);
        send_fields(32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767);
        send_fields(-1, -1, -1, -1, -1, -1, -1, -1, -1);
        send_fields(-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767);
        send_fields(0, 0, 0, 3, 4, 0, 4, -3, 0);
        send_fields(0, 0, 0, 1, 2, 3, 4, 5, 6);
        send_fields(100, -200, 300, -400, 500, -600, 700, -800, 900);
        send_fields(-21846, 21845, -1, 21845, -21846, 1, 12345, -12345, 0);
        drain();   // sender holds until every normal is back

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 58; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 58; end
                default: begin send_idle = 27; recv_stall = 27; end
            endcase
            send_random(470);
            if (ph == 1)
                drain();
        end
        drain();

        $display("%0d triangles sent, %0d normals checked, %0d degenerate",
                 sent, sb.checked, sb.degen_seen);
        $display("four idle/stall phases plus directed corners and collinear cases");
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
